// File: sv/proportional_glyph_layout_core_defines.svh
// assertion macros for the proportional glyph layout checker
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef PROPORTIONAL_GLYPH_LAYOUT_CORE_DEFINES_SVH
`define PROPORTIONAL_GLYPH_LAYOUT_CORE_DEFINES_SVH

// condition holds in the same cycle
`define PGL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pgl assertion failed");

// condition holds in the next cycle
`define PGL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pgl assertion failed");

`endif

// File: sv/pgl_pkg.sv
// shared types and constants for the proportional glyph layout block
// no dependencies
package pgl_pkg;

  localparam logic [6:0] CODE_NEWLINE = 7'h0a;
  localparam logic [6:0] CODE_CARET   = 7'h5e;

  localparam int unsigned CELL_W = 6;
  localparam int unsigned CELL_H = 9;

  localparam logic [4:0] LINE_HEIGHT_RESET = 5'd9;
  localparam int unsigned QUEUE_DEPTH      = 4;

  typedef struct packed {
    logic [6:0]         char_code;
    logic               first;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
  } pgl_in_t;

  typedef struct packed {
    logic [7:0]         src_x;
    logic [4:0]         src_y;
    logic [2:0]         glyph_width;
    logic signed [15:0] dst_x;
    logic signed [15:0] dst_y;
    logic [7:0]         color_red;
    logic [7:0]         color_green;
    logic [7:0]         color_blue;
    logic               digit_error;
  } pgl_out_t;

  typedef struct packed {
    logic [6:0]  char_code;
    logic [2:0]  glyph_width;
    logic [15:0] dst_x;
    logic [15:0] dst_y;
    logic [7:0]  color_red;
    logic [7:0]  color_green;
    logic [7:0]  color_blue;
    logic        digit_error;
  } pgl_cmd_t;

endpackage

// File: sv/proportional_glyph_layout_core.sv
// Proportional glyph layout core. Takes one character per clock while not stalled and turns
// every drawable character into one glyph transaction (atlas source, width, destination, color,
// error flag); newlines and caret color escapes give no transaction. Sustained rate is one
// character per cycle while neither the input nor the output stalls; a glyph passes through the
// command queue into the output register, where it is held while the output is stalled.
// Input stall rises only when the command queue (QueueDepth entries,
// default 4) between the front end and the output register is full. line_height is written
// through the cfg port, which is always ready.
module proportional_glyph_layout_core import pgl_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  pgl_in_t    in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output pgl_out_t   out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [4:0] cfg_data_i
);

  logic [4:0] line_height_q;
  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_valid;
  pgl_cmd_t   cmd_in;
  pgl_cmd_t   cmd_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_height_q <= LINE_HEIGHT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      line_height_q <= cfg_data_i;
    end
  end

  pgl_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_data_i     (in_data_i),
    .line_height_i (line_height_q),
    .q_full_i      (q_full),
    .push_o        (push),
    .cmd_o         (cmd_in)
  );

  pgl_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (cmd_out)
  );

  pgl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (cmd_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: sv/pgl_front.sv
// front end: takes characters, runs the escape decoder and cursor state
// pushes one draw command per glyph into the queue; uses pgl_pkg
module pgl_front import pgl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  pgl_in_t    in_data_i,
  input  logic [4:0] line_height_i,
  input  logic       q_full_i,
  output logic       push_o,
  output pgl_cmd_t   cmd_o
);

  typedef enum logic [1:0] {
    ESC_IDLE,
    ESC_RED,
    ESC_GREEN,
    ESC_BLUE
  } esc_e;

  function automatic logic [2:0] draw_width(input logic [6:0] c);
    logic [2:0] w;
    case (c) inside
      7'h21, 7'h27, 7'h2e, 7'h3a, 7'h7c:                      w = 3'd2;
      7'h28, 7'h29, 7'h2c, 7'h3b, 7'h60:                      w = 3'd3;
      7'h20, 7'h22, 7'h3c, 7'h3d, 7'h3e, 7'h5b, 7'h5d,
      7'h69, 7'h6a, 7'h6c, 7'h7b, 7'h7d:                      w = 3'd4;
      7'h66, 7'h72, 7'h74:                                    w = 3'd5;
      default:                                                w = 3'd6;
    endcase
    return w;
  endfunction

  esc_e        esc_q, esc_d, esc_cur;
  logic [15:0] cur_x_q, cur_x_d, cur_x_cur;
  logic [15:0] cur_y_q, cur_y_d, cur_y_cur;
  logic [15:0] line_x_q, line_x_d, line_x_cur;
  logic [7:0]  red_q, red_d, red_cur;
  logic [7:0]  green_q, green_d, green_cur;
  logic [7:0]  blue_q, blue_d, blue_cur;
  logic        err_q, err_d, err_cur;
  logic        accept;
  logic        glyph;
  logic        hex_ok;
  logic [3:0]  hex_val;
  logic [7:0]  hex_scaled;
  logic [6:0]  c;
  logic [2:0]  w;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign c          = in_data_i.char_code;
  assign w          = draw_width(c);

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    case (c) inside
      [7'h30:7'h39]: hex_val = 4'(c - 7'h30);
      [7'h41:7'h46]: hex_val = 4'(c - 7'h37);
      [7'h61:7'h66]: hex_val = 4'(c - 7'h57);
      default:       hex_ok  = 1'b0;
    endcase
  end

  assign hex_scaled = {hex_val, hex_val};

  always_comb begin
    if (in_data_i.first) begin
      cur_x_cur  = in_data_i.start_x;
      line_x_cur = in_data_i.start_x;
      cur_y_cur  = in_data_i.start_y;
      red_cur    = 8'hff;
      green_cur  = 8'hff;
      blue_cur   = 8'hff;
      esc_cur    = ESC_IDLE;
      err_cur    = 1'b0;
    end else begin
      cur_x_cur  = cur_x_q;
      line_x_cur = line_x_q;
      cur_y_cur  = cur_y_q;
      red_cur    = red_q;
      green_cur  = green_q;
      blue_cur   = blue_q;
      esc_cur    = esc_q;
      err_cur    = err_q;
    end

    cur_x_d  = cur_x_cur;
    cur_y_d  = cur_y_cur;
    line_x_d = line_x_cur;
    red_d    = red_cur;
    green_d  = green_cur;
    blue_d   = blue_cur;
    esc_d    = esc_cur;
    err_d    = err_cur;
    glyph    = 1'b0;

    case (esc_cur)
      ESC_RED: begin
        if (c == CODE_CARET) begin
          red_d   = 8'hff;
          green_d = 8'hff;
          blue_d  = 8'hff;
          esc_d   = ESC_IDLE;
        end else begin
          red_d = hex_scaled;
          err_d = err_cur | !hex_ok;
          esc_d = ESC_GREEN;
        end
      end
      ESC_GREEN: begin
        green_d = hex_scaled;
        err_d   = err_cur | !hex_ok;
        esc_d   = ESC_BLUE;
      end
      ESC_BLUE: begin
        blue_d = hex_scaled;
        err_d  = err_cur | !hex_ok;
        esc_d  = ESC_IDLE;
      end
      default: begin
        if (c == CODE_NEWLINE) begin
          cur_y_d = cur_y_cur + {11'd0, line_height_i};
          cur_x_d = line_x_cur;
        end else if (c == CODE_CARET) begin
          esc_d = ESC_RED;
        end else begin
          glyph   = 1'b1;
          cur_x_d = cur_x_cur + {13'd0, w};
        end
      end
    endcase
  end

  assign push_o            = accept && glyph;
  assign cmd_o.char_code   = c;
  assign cmd_o.glyph_width = w;
  assign cmd_o.dst_x       = cur_x_cur;
  assign cmd_o.dst_y       = cur_y_cur;
  assign cmd_o.color_red   = red_cur;
  assign cmd_o.color_green = green_cur;
  assign cmd_o.color_blue  = blue_cur;
  assign cmd_o.digit_error = err_cur;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q    <= ESC_IDLE;
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      line_x_q <= '0;
      red_q    <= 8'hff;
      green_q  <= 8'hff;
      blue_q   <= 8'hff;
      err_q    <= 1'b0;
    end else if (accept) begin
      esc_q    <= esc_d;
      cur_x_q  <= cur_x_d;
      cur_y_q  <= cur_y_d;
      line_x_q <= line_x_d;
      red_q    <= red_d;
      green_q  <= green_d;
      blue_q   <= blue_d;
      err_q    <= err_d;
    end
  end

endmodule

// File: sv/pgl_queue.sv
// short command queue between the front end and the output stage
// flop storage, one push and one pop per cycle; uses pgl_pkg
module pgl_queue import pgl_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  pgl_cmd_t data_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output pgl_cmd_t data_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  pgl_cmd_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: sv/pgl_back.sv
// back end: takes draw commands from the queue and forms result transactions
// computes the atlas source and holds the output register; uses pgl_pkg
module pgl_back import pgl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     q_valid_i,
  input  pgl_cmd_t q_data_i,
  output logic     pop_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output pgl_out_t out_data_o
);

  logic     out_valid_q, out_valid_d;
  pgl_out_t out_q, out_d;
  logic     load;

  assign load  = q_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o = load;

  always_comb begin
    out_d.src_x       = 8'(q_data_i.char_code[4:0]) * 8'(CELL_W);
    out_d.src_y       = 5'(q_data_i.char_code[6:5]) * 5'(CELL_H);
    out_d.glyph_width = q_data_i.glyph_width;
    out_d.dst_x       = q_data_i.dst_x;
    out_d.dst_y       = q_data_i.dst_y;
    out_d.color_red   = q_data_i.color_red;
    out_d.color_green = q_data_i.color_green;
    out_d.color_blue  = q_data_i.color_blue;
    out_d.digit_error = q_data_i.digit_error;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: sv/pgl_checker.sv
// port-level checker for the proportional glyph layout core, bound to the top level
// uses pgl_pkg and the assertion macros header
`include "proportional_glyph_layout_core_defines.svh"

module pgl_checker import pgl_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input pgl_out_t out_data_o
);

  // a stalled result transaction stays offered
  `PGL_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)

  // a stalled result transaction keeps its payload
  `PGL_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(out_data_o))

  // drawn width lies between two and six
  `PGL_ASSERT_NOW(a_width, out_valid_o, out_data_o.glyph_width >= 3'd2 && out_data_o.glyph_width <= 3'd6)

  // atlas source lies on the cell grid
  `PGL_ASSERT_NOW(a_src, out_valid_o, !out_data_o.src_x[0] && out_data_o.src_x <= 8'd186 && (out_data_o.src_y == 5'd0 || out_data_o.src_y == 5'd9 || out_data_o.src_y == 5'd18 || out_data_o.src_y == 5'd27))

endmodule

bind proportional_glyph_layout_core pgl_checker u_pgl_checker (.*);
